### hdl/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types, codes and constants of the aging priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 16;

	localparam int TAG_W  = 8;
	localparam int KIND_W = 3;
	localparam int PRIO_W = 3;
	localparam int WAIT_W = 4;
	localparam int ACT_W  = 2;
	localparam int THR_W  = 4;
	localparam int CFG_W  = 4;
	localparam int CNT_OUT_W = 5;

	localparam logic [WAIT_W-1:0] WAIT_MAX = 4'd15;

	localparam logic [THR_W-1:0]  THRESHOLD_RESET = 4'd3;
	localparam logic [PRIO_W-1:0] CAP_RESET       = 3'd5;

	// Starting priorities of the kind groups.
	localparam logic [PRIO_W-1:0] PRIO_EMERGENCY = 3'd5;
	localparam logic [PRIO_W-1:0] PRIO_BUS       = 3'd3;
	localparam logic [PRIO_W-1:0] PRIO_TRUCK     = 3'd2;
	localparam logic [PRIO_W-1:0] PRIO_OTHER     = 3'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADMIT = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_SERVE = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_AMBULANCE = 3'd0,
		KIND_FIRETRUCK = 3'd1,
		KIND_POLICE    = 3'd2,
		KIND_BUS       = 3'd3,
		KIND_TRUCK     = 3'd4,
		KIND_OTHER     = 3'd5
	} kind_code_t;

	typedef enum logic {
		CFG_AGING_THRESHOLD = 1'b0,
		CFG_PRIORITY_CAP    = 1'b1
	} cfg_index_t;

	// What every cell does in the current cycle.
	typedef enum logic [2:0] {
		CELL_HOLD  = 3'd0,
		CELL_ADMIT = 3'd1,
		CELL_SERVE = 3'd2,
		CELL_AGE   = 3'd3,
		CELL_SORT  = 3'd4
	} cell_op_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [KIND_W-1:0] kind;
		logic [PRIO_W-1:0] prio;
		logic [WAIT_W-1:0] wait_cnt;
	} apq_entry_t;

	// Broadcast to the whole row.
	typedef struct packed {
		cell_op_t          op;
		logic [THR_W-1:0]  threshold;
		logic [PRIO_W-1:0] cap;
		apq_entry_t        new_entry;
	} apq_ctrl_t;

	// Per-cell neighbourhood information.
	typedef struct packed {
		logic occ_self;
		logic occ_right;
		logic left_ok;
		logic keep_left;
		logic pair_right;
	} apq_link_t;

	function automatic logic [PRIO_W-1:0] start_priority(input logic [KIND_W-1:0] kind);
		logic [PRIO_W-1:0] p;
		case (kind)
			KIND_AMBULANCE, KIND_FIRETRUCK, KIND_POLICE: p = PRIO_EMERGENCY;
			KIND_BUS:   p = PRIO_BUS;
			KIND_TRUCK: p = PRIO_TRUCK;
			default:    p = PRIO_OTHER;
		endcase
		return p;
	endfunction

endpackage

### hdl/apq_cell.sv
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the queue: holds an entry and exchanges it with its neighbours.
// ----------------------------------------------------------------------------
module apq_cell (
	input  logic                clk,
	input  apq_pkg::apq_ctrl_t  ctrl,
	input  apq_pkg::apq_link_t  link,
	input  apq_pkg::apq_entry_t left_entry,
	input  apq_pkg::apq_entry_t right_entry,
	output apq_pkg::apq_entry_t entry,
	output logic                keep
);

	apq_pkg::apq_entry_t entry_q;
	apq_pkg::apq_entry_t aged;
	apq_pkg::apq_entry_t entry_d;
	logic [apq_pkg::WAIT_W-1:0] wait_inc;

	// An occupied cell whose priority is at least the newcomer's stays put on admit.
	assign keep = link.occ_self && (entry_q.prio >= ctrl.new_entry.prio);

	always_comb begin
		aged = entry_q;
		wait_inc = (entry_q.wait_cnt != apq_pkg::WAIT_MAX) ?
			entry_q.wait_cnt + apq_pkg::WAIT_W'(1) : entry_q.wait_cnt;
		aged.wait_cnt = wait_inc;
		if ((wait_inc >= ctrl.threshold) && (entry_q.prio < ctrl.cap)) begin
			aged.prio = entry_q.prio + apq_pkg::PRIO_W'(1);
			aged.wait_cnt = '0;
		end
	end

	always_comb begin
		entry_d = entry_q;
		case (ctrl.op)
			apq_pkg::CELL_HOLD: entry_d = entry_q;
			apq_pkg::CELL_ADMIT: begin
				if (keep) begin
					entry_d = entry_q;
				end else if (link.keep_left) begin
					entry_d = ctrl.new_entry;
				end else begin
					entry_d = left_entry;
				end
			end
			apq_pkg::CELL_SERVE: begin
				if (link.occ_right) begin
					entry_d = right_entry;
				end
			end
			apq_pkg::CELL_AGE: entry_d = aged;
			apq_pkg::CELL_SORT: begin
				// Equal priorities never swap, so the sort keeps arrival order.
				if (link.pair_right) begin
					if (link.occ_right && (entry_q.prio < right_entry.prio)) begin
						entry_d = right_entry;
					end
				end else if (link.left_ok && link.occ_self &&
						(left_entry.prio < entry_q.prio)) begin
					entry_d = left_entry;
				end
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

### hdl/aging_priority_queue.sv
// ----------------------------------------------------------------------------
// aging_priority_queue
// Bounded priority queue with aging, built as a row of compare-exchange cells.
// ----------------------------------------------------------------------------
// Each transaction on the input channel produces exactly one transaction on
// the output channel. Admit, serve and the no-operation code can follow one
// another back to back while the output is not stalled; the result is held in
// an output register, so a new transaction is taken while the previous result
// is being drained. A tick first lets every cell age its entry and then runs
// QUEUE_DEPTH odd-even compare-exchange passes along the cell row, which
// restore descending priority order while keeping entries of equal priority
// in arrival order. Input stall is high during those passes and whenever the
// output register is full and stalled. The configuration registers (aging
// threshold, priority cap) should only be written while the block is idle.
// ----------------------------------------------------------------------------
module aging_priority_queue #(
	parameter int QUEUE_DEPTH = apq_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [apq_pkg::CFG_W-1:0]     cfg_data,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [apq_pkg::ACT_W-1:0]     action,
	input  logic [apq_pkg::KIND_W-1:0]    vehicle_kind,
	input  logic [apq_pkg::TAG_W-1:0]     entry_tag,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          served_valid,
	output logic [apq_pkg::TAG_W-1:0]     served_tag,
	output logic [apq_pkg::KIND_W-1:0]    served_kind,
	output logic [apq_pkg::PRIO_W-1:0]    served_priority,
	output logic                          admit_dropped,
	output logic                          queue_empty,
	output logic [apq_pkg::CNT_OUT_W-1:0] entry_count
);

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int PASS_W = $clog2(QUEUE_DEPTH);

	// Controller states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SORT = 2'b10
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [PASS_W-1:0]   pass_q;
	logic [apq_pkg::THR_W-1:0]  threshold_q;
	logic [apq_pkg::PRIO_W-1:0] cap_q;

	logic                out_valid_q;
	logic                served_valid_q;
	apq_pkg::apq_entry_t served_q;
	logic                dropped_q;
	logic [CNT_W-1:0]    result_count_q;

	logic                in_accept;
	logic                out_free;
	logic                result_load;
	logic                is_full;
	logic                is_empty;
	logic                last_pass;
	apq_pkg::apq_ctrl_t  ctrl;
	apq_pkg::apq_entry_t head;

	apq_pkg::apq_entry_t cell_entry [QUEUE_DEPTH];
	logic                cell_keep  [QUEUE_DEPTH];

	// The output register may be refilled in the same cycle as it is drained.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign in_accept = in_valid && !in_stall;

	// Every transaction but a tick loads its result at once; a tick loads it
	// after the last sort pass.
	assign result_load = ((state_q == ST_IDLE) && in_accept &&
			(apq_pkg::action_t'(action) != apq_pkg::ACT_TICK)) ||
		((state_q == ST_SORT) && last_pass);

	assign is_full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty  = (count_q == '0);
	assign last_pass = (pass_q == PASS_W'(QUEUE_DEPTH - 1));
	assign head      = cell_entry[0];

	// Broadcast command for the row of cells.
	always_comb begin
		ctrl.op                 = apq_pkg::CELL_HOLD;
		ctrl.threshold          = threshold_q;
		ctrl.cap                = cap_q;
		ctrl.new_entry.tag      = entry_tag;
		ctrl.new_entry.kind     = vehicle_kind;
		ctrl.new_entry.prio     = apq_pkg::start_priority(vehicle_kind);
		ctrl.new_entry.wait_cnt = '0;
		if (state_q == ST_SORT) begin
			ctrl.op = apq_pkg::CELL_SORT;
		end else if (in_accept) begin
			case (apq_pkg::action_t'(action))
				apq_pkg::ACT_ADMIT:
					ctrl.op = is_full ? apq_pkg::CELL_HOLD : apq_pkg::CELL_ADMIT;
				apq_pkg::ACT_TICK:  ctrl.op = apq_pkg::CELL_AGE;
				apq_pkg::ACT_SERVE:
					ctrl.op = is_empty ? apq_pkg::CELL_HOLD : apq_pkg::CELL_SERVE;
				apq_pkg::ACT_NOP:   ctrl.op = apq_pkg::CELL_HOLD;
				default:            ctrl.op = apq_pkg::CELL_HOLD;
			endcase
		end
	end

	// The row of cells. Cell 0 is the head of the queue; a cell is occupied
	// when its position is below the entry count.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		apq_pkg::apq_link_t  link;
		apq_pkg::apq_entry_t left_e;
		apq_pkg::apq_entry_t right_e;

		always_comb begin
			link.occ_self   = (CNT_W'(i) < count_q);
			link.occ_right  = (i + 1 < QUEUE_DEPTH) && (CNT_W'(i + 1) < count_q);
			link.left_ok    = (i > 0);
			// In even passes cells 0-1, 2-3, ... compare; in odd passes 1-2, 3-4, ...
			link.pair_right = ((i % 2) == 0) ? !pass_q[0] : pass_q[0];
			link.keep_left  = (i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1];
			left_e          = (i == 0) ? ctrl.new_entry : cell_entry[(i == 0) ? 0 : i - 1];
			right_e         = (i + 1 < QUEUE_DEPTH) ?
				cell_entry[(i + 1 < QUEUE_DEPTH) ? i + 1 : i] : cell_entry[i];
		end

		apq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.link        (link),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= apq_pkg::THRESHOLD_RESET;
			cap_q       <= apq_pkg::CAP_RESET;
		end else if (cfg_write) begin
			case (apq_pkg::cfg_index_t'(cfg_index))
				apq_pkg::CFG_AGING_THRESHOLD: threshold_q <= cfg_data;
				apq_pkg::CFG_PRIORITY_CAP:    cap_q <= cfg_data[apq_pkg::PRIO_W-1:0];
				default: ;
			endcase
		end
	end

	// Controller: entry count, sort pass counter and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						case (apq_pkg::action_t'(action))
							apq_pkg::ACT_ADMIT: begin
								if (!is_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							apq_pkg::ACT_TICK: begin
								// The result is issued after the last sort pass.
								state_q <= ST_SORT;
								pass_q  <= '0;
							end
							apq_pkg::ACT_SERVE: begin
								if (!is_empty) begin
									count_q <= count_q - CNT_W'(1);
								end
							end
							default: ;
						endcase
					end
				end
				ST_SORT: begin
					if (last_pass) begin
						state_q <= ST_IDLE;
					end else begin
						pass_q <= pass_q + PASS_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_SORT) begin
			if (last_pass) begin
				served_valid_q <= 1'b0;
				served_q       <= '0;
				dropped_q      <= 1'b0;
				result_count_q <= count_q;
			end
		end else if (in_accept) begin
			case (apq_pkg::action_t'(action))
				apq_pkg::ACT_ADMIT: begin
					served_valid_q <= 1'b0;
					served_q       <= '0;
					dropped_q      <= is_full;
					result_count_q <= is_full ? count_q : count_q + CNT_W'(1);
				end
				apq_pkg::ACT_SERVE: begin
					served_valid_q <= !is_empty;
					served_q       <= is_empty ? '0 : head;
					dropped_q      <= 1'b0;
					result_count_q <= is_empty ? count_q : count_q - CNT_W'(1);
				end
				default: begin
					served_valid_q <= 1'b0;
					served_q       <= '0;
					dropped_q      <= 1'b0;
					result_count_q <= count_q;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign served_valid    = served_valid_q;
	assign served_tag      = served_q.tag;
	assign served_kind     = served_q.kind;
	assign served_priority = served_q.prio;
	assign admit_dropped   = dropped_q;
	assign queue_empty     = (result_count_q == '0);
	assign entry_count     = apq_pkg::CNT_OUT_W'(result_count_q);

	// The entry count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	// An admit into a full queue is reported as dropped and leaves the count alone.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (action == apq_pkg::ACT_ADMIT) && is_full)
		|=> (out_valid && admit_dropped && (count_q == $past(count_q))))
		else $error("admit to full queue not flagged");

	// A serve of a non-empty queue reports an entry and shrinks the queue by one.
	a_serve: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (action == apq_pkg::ACT_SERVE) && !is_empty)
		|=> (out_valid && served_valid && (count_q == $past(count_q) - CNT_W'(1))))
		else $error("serve did not remove the head");

	// No new transaction is taken while the sort passes run.
	a_sort_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |-> (in_stall && !in_accept))
		else $error("input taken during sort");

endmodule
